// ===== hdl/dplc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplc_pkg
// Shared types and constants of the demand power lease controller: item
// codes, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dplc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned REQ_DATA_WIDTH  = 48;
   localparam int unsigned RSP_DATA_WIDTH  = 16;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_TOUCH   = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEASE_TIME     = 3'd0,
      CSR_LINGER_TIME    = 3'd1,
      CSR_FAIL_COOLDOWN  = 3'd2,
      CSR_STOP_COOLDOWN  = 3'd3,
      CSR_LEASE_BIT_MASK = 3'd4
   } csr_index_type;

   localparam logic [15:0] LEASE_TIME_RESET     = 16'd2500;
   localparam logic [15:0] LINGER_TIME_RESET    = 16'd3000;
   localparam logic [15:0] FAIL_COOLDOWN_RESET  = 16'd5000;
   localparam logic [15:0] STOP_COOLDOWN_RESET  = 16'd2000;
   localparam logic [7:0]  LEASE_BIT_MASK_RESET = 8'd8;

   typedef struct packed {
      logic [15:0] lease_time;
      logic [15:0] linger_time;
      logic [15:0] fail_cooldown;
      logic [15:0] stop_cooldown;
      logic [7:0]  lease_bit_mask;
   } cfg_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  reasons;
      logic [31:0] now_ms;
      logic        device_running;
      logic        start_ok;
   } req_item_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] effective_need;
      logic       start_failed;
   } rsp_item_type;

endpackage

// ===== hdl/dplc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplc_csr
// Configuration register bank: lease, linger, cooldowns and lease bit mask.
// ----------------------------------------------------------------------------
module dplc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dplc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dplc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output dplc_pkg::cfg_type                      cfg
);

   dplc_pkg::cfg_type cfg_ff;
   dplc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (dplc_pkg::csr_index_type'(csr_index))
            dplc_pkg::CSR_LEASE_TIME:     cfg_in.lease_time     = csr_wdata;
            dplc_pkg::CSR_LINGER_TIME:    cfg_in.linger_time    = csr_wdata;
            dplc_pkg::CSR_FAIL_COOLDOWN:  cfg_in.fail_cooldown  = csr_wdata;
            dplc_pkg::CSR_STOP_COOLDOWN:  cfg_in.stop_cooldown  = csr_wdata;
            dplc_pkg::CSR_LEASE_BIT_MASK: cfg_in.lease_bit_mask = csr_wdata[7:0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lease_time     <= dplc_pkg::LEASE_TIME_RESET;
         cfg_ff.linger_time    <= dplc_pkg::LINGER_TIME_RESET;
         cfg_ff.fail_cooldown  <= dplc_pkg::FAIL_COOLDOWN_RESET;
         cfg_ff.stop_cooldown  <= dplc_pkg::STOP_COOLDOWN_RESET;
         cfg_ff.lease_bit_mask <= dplc_pkg::LEASE_BIT_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/dplc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplc_engine
// Need and timestamp state plus the single-pass decision logic for one item.
// ----------------------------------------------------------------------------
module dplc_engine #(
   parameter int unsigned NEED_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  dplc_pkg::req_item_type item,
   input  dplc_pkg::cfg_type      cfg,
   output dplc_pkg::rsp_item_type result
);

   logic [NEED_BITS-1:0] static_need_ff, static_need_in;
   logic [31:0]          touch_time_ff, touch_time_in;
   logic [31:0]          last_need_time_ff, last_need_time_in;
   logic [31:0]          last_fail_time_ff, last_fail_time_in;
   logic [31:0]          last_stop_time_ff, last_stop_time_in;

   logic [NEED_BITS-1:0] reasons_n;
   logic [NEED_BITS-1:0] lease_mask_n;
   logic [NEED_BITS-1:0] eff;
   logic [31:0]          since_touch;
   logic [31:0]          since_need;
   logic [31:0]          since_fail;
   logic [31:0]          since_stop;
   logic                 lease_active;
   logic                 may_start;
   logic                 may_stop;

   assign reasons_n    = NEED_BITS'(item.reasons);
   assign lease_mask_n = NEED_BITS'(cfg.lease_bit_mask);

   assign since_touch = item.now_ms - touch_time_ff;
   assign since_need  = item.now_ms - last_need_time_ff;
   assign since_fail  = item.now_ms - last_fail_time_ff;
   assign since_stop  = item.now_ms - last_stop_time_ff;

   assign lease_active = since_touch < {16'd0, cfg.lease_time};
   assign eff          = static_need_ff | (lease_active ? lease_mask_n : '0);
   assign may_start    = !item.device_running
                         && since_fail >= {16'd0, cfg.fail_cooldown}
                         && since_stop >= {16'd0, cfg.stop_cooldown};
   assign may_stop     = item.device_running && since_need >= {16'd0, cfg.linger_time};

   always_comb begin
      static_need_in    = static_need_ff;
      touch_time_in     = touch_time_ff;
      last_need_time_in = last_need_time_ff;
      last_fail_time_in = last_fail_time_ff;
      last_stop_time_in = last_stop_time_ff;
      result            = '0;
      result.command    = dplc_pkg::CMD_NONE;
      unique case (item.operation)
         dplc_pkg::OP_ACQUIRE: static_need_in = static_need_ff | reasons_n;
         dplc_pkg::OP_RELEASE: static_need_in = static_need_ff & ~reasons_n;
         dplc_pkg::OP_TOUCH:   touch_time_in  = item.now_ms;
         dplc_pkg::OP_TICK: begin
            result.effective_need = 8'(eff);
            if (eff != '0) begin
               last_need_time_in = item.now_ms;
               if (may_start) begin
                  result.command = dplc_pkg::CMD_START;
                  if (!item.start_ok) begin
                     // record the failed start to hold off the next retry
                     last_fail_time_in   = item.now_ms;
                     result.start_failed = 1'b1;
                  end
               end
            end else if (may_stop) begin
               result.command    = dplc_pkg::CMD_STOP;
               last_stop_time_in = item.now_ms;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         static_need_ff    <= '0;
         touch_time_ff     <= '0;
         last_need_time_ff <= '0;
         last_fail_time_ff <= '0;
         last_stop_time_ff <= '0;
      end else if (fire) begin
         static_need_ff    <= static_need_in;
         touch_time_ff     <= touch_time_in;
         last_need_time_ff <= last_need_time_in;
         last_fail_time_ff <= last_fail_time_in;
         last_stop_time_ff <= last_stop_time_in;
      end
   end

endmodule

// ===== hdl/demand_power_lease_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_power_lease_controller_core
// Demand-driven power controller for one device with need bits, a web lease,
// linger before stop and cooldowns before start.
// ----------------------------------------------------------------------------
// Every request item gives exactly one response item, in order. The block
// takes one item per cycle while responses are read, and passes each item
// through the input register, the decision logic against the state and the
// response register. The input register moves on whenever the response
// register is empty or being read. While a response waits on rsp_tready, one
// more item is taken and held in the input register, and req_tready then
// stays low until the response leaves. The state is
// updated as an item leaves the input register, so each item sees the effect
// of the one before. Configuration writes are taken in any cycle and should
// be made while no item is in flight.
// ----------------------------------------------------------------------------
module demand_power_lease_controller_core #(
   parameter int unsigned NEED_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: reasons[7:0], now_ms[39:8], device_running[40], start_ok[41], zero pad
   input  logic [dplc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]                           req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: effective_need[7:0], start_failed[8], zero pad
   output logic [dplc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // tuser: command[1:0]
   output logic [1:0]                           rsp_tuser,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dplc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dplc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   dplc_pkg::cfg_type      cfg;
   dplc_pkg::req_item_type req_item;
   dplc_pkg::rsp_item_type result;

   logic                   in_valid_ff, in_valid_in;
   dplc_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   dplc_pkg::rsp_item_type out_item_ff;
   logic                   advance;
   logic                   accept;

   assign req_item.operation      = dplc_pkg::op_type'(req_tuser);
   assign req_item.reasons        = req_tdata[7:0];
   assign req_item.now_ms         = req_tdata[39:8];
   assign req_item.device_running = req_tdata[40];
   assign req_item.start_ok       = req_tdata[41];

   // move the held item into the response register when it is free
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   dplc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dplc_engine #(
      .NEED_BITS (NEED_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.command;
   assign rsp_tdata  = {7'd0, out_item_ff.start_failed, out_item_ff.effective_need};

endmodule

// ===== hdl/dplc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dplc_checker
// Port-level checks of the power lease controller, bound to the top level.
// ----------------------------------------------------------------------------
module dplc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dplc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [1:0]                          rsp_tuser
);

   // a failed start is only reported on a start command
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tuser == dplc_pkg::CMD_START)
      else $error("start_failed without a start command");

   // a stop is only issued when the tick saw no need
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dplc_pkg::CMD_STOP |-> rsp_tdata[7:0] == 8'd0)
      else $error("stop issued with need present");

   // a start is only issued when the tick saw need
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dplc_pkg::CMD_START |-> rsp_tdata[7:0] != 8'd0)
      else $error("start issued without need");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind demand_power_lease_controller_core dplc_checker u_dplc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for demand_power_lease_controller_core. A table of
// directed items covers reset values, threshold edges, time wrap and ignored
// fields. Random items follow under five register settings, zero and full
// scale among them. Each response is checked against its expected item from
// the table or from an in-bench model of the need, lease, linger and cooldown
// logic. Sender gaps and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb;
   import dplc_pkg::*;

   localparam int unsigned PHASE_ITEMS = 150;
   localparam int unsigned SHOWN_ERRORS = 10;

   typedef struct packed {
      op_type       op;
      logic [7:0]   reasons;
      logic [31:0]  now_ms;
      logic         running;
      logic         ok;
      logic         typed;
      rsp_item_type want;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic [1:0]                 req_tuser = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic [1:0]                 rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // model state
   cfg_type      lease_cfg;
   logic [7:0]   held_need;
   logic [31:0]  touch_ms;
   logic [31:0]  need_ms;
   logic [31:0]  fail_ms;
   logic [31:0]  stop_ms;

   rsp_item_type pending_decisions[$];
   rsp_item_type seen;
   rsp_item_type owed;
   plan_row_type plan [22];

   int unsigned  req_gap_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   int unsigned  mismatches = 0;
   int unsigned  items_sent = 0;
   int unsigned  rsp_checked = 0;
   int unsigned  starts_seen = 0;
   int unsigned  fails_seen = 0;
   int unsigned  stops_seen = 0;
   logic [31:0]  wall_ms = 32'h0000_2000;
   logic         plant_on = 1'b0;

   demand_power_lease_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endfunction

   // Apply one item to the model state and return the decision it causes.
   function automatic rsp_item_type decide_power(req_item_type it);
      rsp_item_type r;
      logic [7:0]   need;
      logic [31:0]  since_touch;
      logic [31:0]  since_need;
      logic [31:0]  since_fail;
      logic [31:0]  since_stop;
      r.command = CMD_NONE;
      r.effective_need = 8'h00;
      r.start_failed = 1'b0;
      since_touch = it.now_ms - touch_ms;
      since_need = it.now_ms - need_ms;
      since_fail = it.now_ms - fail_ms;
      since_stop = it.now_ms - stop_ms;
      case (it.operation)
         OP_ACQUIRE: held_need = held_need | it.reasons;
         OP_RELEASE: held_need = held_need & ~it.reasons;
         OP_TOUCH:   touch_ms = it.now_ms;
         default: begin
            need = held_need;
            if (since_touch < {16'd0, lease_cfg.lease_time}) begin
               need = need | lease_cfg.lease_bit_mask;
            end
            r.effective_need = need;
            if (need != 8'h00) begin
               need_ms = it.now_ms;
               if (!it.device_running &&
                   since_fail >= {16'd0, lease_cfg.fail_cooldown} &&
                   since_stop >= {16'd0, lease_cfg.stop_cooldown}) begin
                  r.command = CMD_START;
                  if (!it.start_ok) begin
                     fail_ms = it.now_ms;
                     r.start_failed = 1'b1;
                  end
               end
            end else if (it.device_running &&
                         since_need >= {16'd0, lease_cfg.linger_time}) begin
               r.command = CMD_STOP;
               stop_ms = it.now_ms;
            end
         end
      endcase
      return r;
   endfunction

   // Called at a rising edge; returns at the edge where the item was taken.
   task automatic send_item(req_item_type it, logic typed, rsp_item_type want);
      rsp_item_type r;
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.operation;
      req_tdata  <= {6'd0, it.start_ok, it.device_running, it.now_ms, it.reasons};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = decide_power(it);
      pending_decisions.push_back(typed ? want : r);
      items_sent++;
      // track the device as a well-behaved plant would
      if (r.command == CMD_START && !r.start_failed) plant_on = 1'b1;
      if (r.command == CMD_STOP) plant_on = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_decisions.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_LEASE_TIME:     lease_cfg.lease_time = value;
         CSR_LINGER_TIME:    lease_cfg.linger_time = value;
         CSR_FAIL_COOLDOWN:  lease_cfg.fail_cooldown = value;
         CSR_STOP_COOLDOWN:  lease_cfg.stop_cooldown = value;
         CSR_LEASE_BIT_MASK: lease_cfg.lease_bit_mask = value[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(logic [15:0] lease, logic [15:0] linger,
                                logic [15:0] fail_cd, logic [15:0] stop_cd,
                                logic [7:0] mask);
      write_csr(CSR_LEASE_TIME, lease);
      write_csr(CSR_LINGER_TIME, linger);
      write_csr(CSR_FAIL_COOLDOWN, fail_cd);
      write_csr(CSR_STOP_COOLDOWN, stop_cd);
      write_csr(CSR_LEASE_BIT_MASK, {8'd0, mask});
   endtask

   task automatic random_item(output req_item_type it, input int unsigned step_max);
      int unsigned pick;
      // mostly advance time in small steps; jump now and then to toggle high bits
      if ($urandom_range(99) < 4) begin
         wall_ms = $urandom;
      end else begin
         wall_ms = wall_ms + $urandom_range(step_max);
      end
      pick = $urandom_range(99);
      if (pick < 15) it.operation = OP_ACQUIRE;
      else if (pick < 30) it.operation = OP_RELEASE;
      else if (pick < 48) it.operation = OP_TOUCH;
      else it.operation = OP_TICK;
      if ($urandom_range(1) == 0) it.reasons = 8'd1 << $urandom_range(7);
      else it.reasons = 8'($urandom_range(255));
      it.now_ms = wall_ms;
      it.device_running = plant_on ^ ($urandom_range(99) < 8);
      it.start_ok = ($urandom_range(99) < 70);
   endtask

   // response side: check, then pick the ready for the next cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.command = cmd_type'(rsp_tuser);
            seen.effective_need = rsp_tdata[7:0];
            seen.start_failed = rsp_tdata[8];
            rsp_checked++;
            if (pending_decisions.size() == 0) begin
               flag_error($sformatf("response with nothing outstanding: cmd %0d need %h",
                                    rsp_tuser, rsp_tdata[7:0]));
            end else begin
               owed = pending_decisions.pop_front();
               if (seen.command == CMD_START) starts_seen++;
               if (seen.command == CMD_STOP) stops_seen++;
               if (seen.start_failed) fails_seen++;
               if (seen.command != owed.command ||
                   seen.effective_need != owed.effective_need ||
                   seen.start_failed != owed.start_failed) begin
                  flag_error($sformatf(
                     "response %0d: expected cmd %0d need %h failed %b, got cmd %0d need %h failed %b",
                     rsp_checked, owed.command, owed.effective_need, owed.start_failed,
                     seen.command, seen.effective_need, seen.start_failed));
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      #400000;
      $display("demand_power_lease_controller_core verification failed");
      $finish;
   end

   initial begin
      req_item_type it;
      rsp_item_type none;
      int unsigned  k;
      int unsigned  phase;
      int unsigned  n;
      int unsigned  step_ms;
      int unsigned  guard;

      lease_cfg = '{LEASE_TIME_RESET, LINGER_TIME_RESET, FAIL_COOLDOWN_RESET,
                    STOP_COOLDOWN_RESET, LEASE_BIT_MASK_RESET};
      held_need = 8'h00;
      touch_ms = '0;
      need_ms = '0;
      fail_ms = '0;
      stop_ms = '0;
      none = '{CMD_NONE, 8'h00, 1'b0};

      // reset settings; lease and cooldowns all count from time zero
      plan = '{
         '{OP_TICK,    8'h00, 32'd0,          1'b0, 1'b1, 1'b1, '{CMD_NONE,  8'h08, 1'b0}},
         '{OP_TICK,    8'h00, 32'd2499,       1'b1, 1'b0, 1'b1, '{CMD_NONE,  8'h08, 1'b0}},
         '{OP_TICK,    8'h00, 32'd2500,       1'b1, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'd5499,       1'b1, 1'b0, 1'b1, '{CMD_STOP,  8'h00, 1'b0}},
         '{OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'd6000,       1'b0, 1'b0, 1'b1, '{CMD_NONE,  8'hFF, 1'b0}},
         '{OP_TICK,    8'h00, 32'd7499,       1'b0, 1'b0, 1'b1, '{CMD_START, 8'hFF, 1'b1}},
         '{OP_TICK,    8'h00, 32'd12498,      1'b0, 1'b1, 1'b1, '{CMD_NONE,  8'hFF, 1'b0}},
         '{OP_TICK,    8'h00, 32'd12499,      1'b0, 1'b1, 1'b1, '{CMD_START, 8'hFF, 1'b0}},
         '{OP_RELEASE, 8'h0F, 32'd0,          1'b0, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'd12500,      1'b1, 1'b1, 1'b1, '{CMD_NONE,  8'hF0, 1'b0}},
         '{OP_RELEASE, 8'hFF, 32'd0,          1'b0, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_ACQUIRE, 8'h00, 32'd0,          1'b0, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TOUCH,   8'h00, 32'hFFFF_FF00,  1'b0, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         // lease measured across the wrap of now_ms
         '{OP_TICK,    8'h00, 32'h0000_00F0,  1'b1, 1'b0, 1'b1, '{CMD_NONE,  8'h08, 1'b0}},
         '{OP_TICK,    8'h00, 32'h0000_08C4,  1'b1, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'h0000_0CA8,  1'b1, 1'b0, 1'b1, '{CMD_STOP,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'h0000_0CA9,  1'b0, 1'b1, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_ACQUIRE, 8'h01, 32'd0,          1'b0, 1'b0, 1'b1, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'h0000_1478,  1'b0, 1'b0, 1'b1, '{CMD_START, 8'h01, 1'b1}},
         '{OP_TICK,    8'hFF, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, '{CMD_NONE,  8'h00, 1'b0}},
         '{OP_TICK,    8'h00, 32'h0000_1500,  1'b0, 1'b1, 1'b0, '{CMD_NONE,  8'h00, 1'b0}}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct = 13;
      rsp_stall_pct = 63;
      for (k = 0; k < $size(plan); k++) begin
         it.operation = plan[k].op;
         it.reasons = plan[k].reasons;
         it.now_ms = plan[k].now_ms;
         it.device_running = plan[k].running;
         it.start_ok = plan[k].ok;
         send_item(it, plan[k].typed, plan[k].want);
      end

      for (phase = 0; phase < 5; phase++) begin
         if (phase == 2) begin
            req_gap_pct = 63;
            rsp_stall_pct = 13;
         end else if (phase == 4) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         wait_drained();
         case (phase)
            0: begin
               load_settings(16'd1200, 16'd800, 16'd600, 16'd400, 8'h30);
               step_ms = 500;
            end
            1: begin
               load_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
               step_ms = 50;
            end
            2: begin
               load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
               step_ms = 20000;
            end
            3: begin
               load_settings(16'($urandom_range(4000)), 16'($urandom_range(4000)),
                             16'($urandom_range(4000)), 16'($urandom_range(4000)),
                             8'($urandom_range(255)));
               step_ms = 1500;
            end
            default: begin
               load_settings(16'($urandom_range(9000)), 16'($urandom_range(9000)),
                             16'($urandom_range(9000)), 16'($urandom_range(9000)),
                             8'($urandom_range(255)));
               step_ms = 3000;
               // run the last setting through the wrap of the clock
               wall_ms = 32'hFFFF_F000;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) wait_drained();
            random_item(it, step_ms);
            send_item(it, 1'b0, none);
         end
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_decisions.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (pending_decisions.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", pending_decisions.size()));
      end

      $display("%0d items sent, %0d responses checked under reset and five register settings",
               items_sent, rsp_checked);
      $display("responses held %0d starts (%0d failed) and %0d stops; %0d errors",
               starts_seen, fails_seen, stops_seen, mismatches);
      if (mismatches == 0) begin
         $display("demand_power_lease_controller_core verification clean");
      end else begin
         $display("demand_power_lease_controller_core verification failed");
      end
      $finish;
   end

endmodule
